// ===== rtl/nsc_pkg.sv =====
// shared constants and types for the streaming substring counter
package nsc_pkg;

  // fixed field widths
  localparam int ByteW = 8;
  localparam int PatW  = 64;
  localparam int LenW  = 4;
  localparam int OccW  = 16;
  localparam int CmpW  = 19;
  localparam int CfgW  = PatW;

  // longest pattern the cell row can hold
  localparam int MaxPatternDef = 8;

  // longest text the counters are sized for
  localparam longint MaxText = 65535;

  // occurrence counter limit
  localparam longint OccCapL = (MaxText < 65535) ? MaxText : 65535;
  localparam logic [OccW-1:0] OccCap = OccW'(OccCapL);

  // configuration register indexes
  typedef enum logic [0:0] {
    RegPatternBytes  = 1'b0,
    RegPatternLength = 1'b1
  } nsc_reg_e;

  // one result beat
  typedef struct packed {
    logic [OccW-1:0] occurrence_count;
    logic [CmpW-1:0] comparison_count;
    logic            text_done;
  } nsc_result_t;

endpackage

// ===== rtl/naive_substring_count_top.sv =====
// top level of the streaming substring counter
//
// Counts how often a pattern of 1 to MAX_PATTERN bytes occurs in a text
// that arrives one byte per input beat, and how many character comparisons
// a naive scan would make. Program pattern_bytes (index 0) and
// pattern_length (index 1) through the write port while the block is idle.
// Input beats carry text_byte_i and last_byte_i on a valid/ready channel;
// every input beat gives exactly one result beat with the running totals,
// and the beat with last_byte_i set returns text_done_o and the final totals,
// after which the window and totals clear for the next text.
// A row of MAX_PATTERN cells holds the window; each beat shifts it by one
// cell and all cells compare in parallel, so one byte is taken per cycle
// while in_ready_o is high. Result beats are registered; throughput is one
// beat per cycle: an output register plus one skid entry let the input be
// taken while a result waits; in_ready_o drops only once both are full.
// Reset clears the window, totals and buffers, and sets pattern_length to 1
// and pattern_bytes to zero.
module naive_substring_count_top
  import nsc_pkg::*;
#(
  parameter int MAX_PATTERN = MaxPatternDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OccW-1:0]  occurrence_count_o,
  output logic [CmpW-1:0]  comparison_count_o,
  output logic             text_done_o
);

  logic [PatW-1:0]        pat_q;
  logic [LenW-1:0]        len_q;
  logic [LenW-1:0]        len_used;
  logic                   step;
  logic [ByteW-1:0]       cell_in   [MAX_PATTERN];
  logic [ByteW-1:0]       cell_out  [MAX_PATTERN];
  logic [ByteW-1:0]       cell_pat  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;
  nsc_result_t            result;
  nsc_result_t            out_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      len_q <= LenW'(1);
    end else if (cfg_we_i) begin
      case (nsc_reg_e'(cfg_idx_i))
        RegPatternBytes:  pat_q <= cfg_data_i;
        RegPatternLength: len_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // length in use: zero means one, clipped to the row length
  always_comb begin
    if (len_q == '0) begin
      len_used = LenW'(1);
    end else if (len_q > LenW'(MAX_PATTERN)) begin
      len_used = LenW'(MAX_PATTERN);
    end else begin
      len_used = len_q;
    end
  end

  assign step = in_valid_i && in_ready_o;

  // cell row: cell k compares the byte k places back with pattern char len-1-k
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [2:0] pidx;
    assign pidx = 3'(len_used - LenW'(1) - LenW'(k));
    assign cell_pat[k] = pat_q[ByteW*pidx +: ByteW];
    if (k == 0) begin : g_head
      assign cell_in[k] = text_byte_i;
    end else begin : g_body
      assign cell_in[k] = cell_out[k-1];
    end

    nsc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (step),
      .clear_i (last_byte_i),
      .data_i  (cell_in[k]),
      .pat_i   (cell_pat[k]),
      .data_o  (cell_out[k]),
      .eq_o    (eq[k])
    );
  end

  // mismatch search and totals
  nsc_accum #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .last_i   (last_byte_i),
    .len_i    (len_used),
    .eq_i     (eq),
    .result_o (result)
  );

  // result buffering
  nsc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .data_i  (result),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign occurrence_count_o = out_data.occurrence_count;
  assign comparison_count_o = out_data.comparison_count;
  assign text_done_o        = out_data.text_done;

endmodule

// ===== rtl/nsc_cell.sv =====
// one window cell: holds a text byte, shifts it on, compares the incoming byte
module nsc_cell
  import nsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             clear_i,
  input  logic [ByteW-1:0] data_i,
  input  logic [ByteW-1:0] pat_i,
  output logic [ByteW-1:0] data_o,
  output logic             eq_o
);

  logic [ByteW-1:0] byte_q;

  // byte register, cleared when the text closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (shift_i) begin
      byte_q <= clear_i ? '0 : data_i;
    end
  end

  // compare the byte this cell takes on the current beat
  assign eq_o   = (data_i == pat_i);
  assign data_o = byte_q;

endmodule

// ===== rtl/nsc_accum.sv =====
// first-mismatch search over the cell row and the saturating running totals
module nsc_accum
  import nsc_pkg::*;
#(
  parameter int MAX_PATTERN = MaxPatternDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   last_i,
  input  logic [LenW-1:0]        len_i,
  input  logic [MAX_PATTERN-1:0] eq_i,
  output nsc_result_t            result_o
);

  localparam int SeenW = $clog2(MAX_PATTERN + 1);
  localparam longint CmpProd = MaxText * MAX_PATTERN;
  localparam longint CmpCapL = (CmpProd < 524287) ? CmpProd : 524287;
  localparam logic [CmpW-1:0] CmpCap = CmpW'(CmpCapL);
  localparam logic [SeenW-1:0] SeenMax = SeenW'(MAX_PATTERN);

  logic [SeenW-1:0] seen_q, seen_d;
  logic [OccW-1:0]  occ_q, occ_d;
  logic [CmpW-1:0]  cmp_q, cmp_d;
  logic [LenW-1:0]  cmps;
  logic             full;
  logic [CmpW:0]    cmp_sum;

  // count of bytes in the window, saturating at the row length
  assign seen_d = (seen_q == SeenMax) ? seen_q : seen_q + 1'b1;

  // highest active cell that mismatched is the first mismatching pattern char
  always_comb begin
    cmps = len_i;
    full = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((LenW'(k) < len_i) && !eq_i[k]) begin
        cmps = len_i - LenW'(k);
        full = 1'b0;
      end
    end
  end

  // new totals for this beat
  assign cmp_sum = {1'b0, cmp_q} + (CmpW + 1)'(cmps);

  always_comb begin
    occ_d = occ_q;
    cmp_d = cmp_q;
    if (LenW'(seen_d) >= len_i) begin
      if (full && (occ_q < OccCap)) begin
        occ_d = occ_q + 1'b1;
      end
      cmp_d = (cmp_sum > (CmpW + 1)'(CmpCap)) ? CmpCap : cmp_sum[CmpW-1:0];
    end
  end

  // totals registers, cleared after the closing beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      occ_q  <= '0;
      cmp_q  <= '0;
    end else if (step_i) begin
      seen_q <= last_i ? '0 : seen_d;
      occ_q  <= last_i ? '0 : occ_d;
      cmp_q  <= last_i ? '0 : cmp_d;
    end
  end

  assign result_o.occurrence_count = occ_d;
  assign result_o.comparison_count = cmp_d;
  assign result_o.text_done        = last_i;

endmodule

// ===== rtl/nsc_out_buf.sv =====
// output register with a skid stage so the input side keeps flowing
module nsc_out_buf
  import nsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  nsc_result_t data_i,
  output logic        ready_o,
  output logic        valid_o,
  input  logic        ready_i,
  output nsc_result_t data_o
);

  logic        out_valid_q;
  logic        skid_valid_q;
  nsc_result_t out_q;
  nsc_result_t skid_q;
  logic        pop;

  assign pop     = out_valid_q && ready_i;
  assign ready_o = !skid_valid_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= data_i;
      end else begin
        out_q <= data_i;
      end
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule
